@@ hdl/a64alu_pkg.sv @@
// Package with the operation, shift and extend codes of the integer ALU.
`timescale 1ns / 1ps
`default_nettype none

package a64alu_pkg;

    // Operation codes.
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_AND  = 4'd2;
    localparam logic [3:0] OP_ORR  = 4'd3;
    localparam logic [3:0] OP_EOR  = 4'd4;
    localparam logic [3:0] OP_ADDS = 4'd5;
    localparam logic [3:0] OP_SUBS = 4'd6;
    localparam logic [3:0] OP_ANDS = 4'd7;
    localparam logic [3:0] OP_BICS = 4'd8;
    localparam logic [3:0] OP_NEG  = 4'd9;
    localparam logic [3:0] OP_NEGS = 4'd10;
    localparam logic [3:0] OP_MOVZ = 4'd11;
    localparam logic [3:0] OP_MOVK = 4'd12;
    localparam logic [3:0] OP_MOVN = 4'd13;

    // Shift kinds for the second operand.
    localparam logic [2:0] SK_NONE = 3'd0;
    localparam logic [2:0] SK_LSL  = 3'd1;
    localparam logic [2:0] SK_LSR  = 3'd2;
    localparam logic [2:0] SK_ASR  = 3'd3;
    localparam logic [2:0] SK_ROR  = 3'd4;

    // Extend kinds for the second operand.
    localparam logic [3:0] EXT_NONE = 4'd0;
    localparam logic [3:0] EXT_UXTB = 4'd1;
    localparam logic [3:0] EXT_UXTH = 4'd2;
    localparam logic [3:0] EXT_UXTW = 4'd3;
    localparam logic [3:0] EXT_UXTX = 4'd4;
    localparam logic [3:0] EXT_SXTB = 4'd5;
    localparam logic [3:0] EXT_SXTH = 4'd6;
    localparam logic [3:0] EXT_SXTW = 4'd7;
    localparam logic [3:0] EXT_SXTX = 4'd8;

    // Field constants.
    localparam logic [15:0] IMM16_MASK      = 16'hFFFF;
    localparam logic [5:0]  WIDE_CNT_MASK   = 6'd63;
    localparam logic [5:0]  NARROW_CNT_MASK = 6'd31;

    // Clear the upper word in 32-bit mode.
    function automatic logic [63:0] fit_width(input logic [63:0] val, input logic wide);
        fit_width = wide ? val : {32'd0, val[31:0]};
    endfunction

endpackage

`default_nettype wire

@@ hdl/arm64_alu_with_flags_core.sv @@
// Top level of the pipelined 64-bit integer ALU with NZCV flags.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A transaction enters when start is high at a rising clock edge while busy is
// low. The ALU never stalls, so busy stays low and a new transaction can enter
// in every cycle. Each transaction carries an opcode, the width flag, the first
// operand, the raw second operand with its shift or extend kind and amount, and
// the old destination value for the keep-move form.
// The pipeline has four register ranks: input capture, second-operand shift and
// extend, the adder and logic unit, and flag generation. The result of an
// accepted transaction passes through the four ranks in order and is shown on
// the o_ ports for exactly one cycle, marked by o_strobe; throughput is one
// transaction per cycle. The barrel shifters of the operand stage and the
// 65-bit adder set the depth of the two middle stages.
// The receiver cannot hold results off: every result is taken in the cycle in
// which o_strobe is high.
// A synchronous low on i_rst_n clears all valid bits, which drops any
// transaction in flight; payload registers are not reset.
module arm64_alu_with_flags_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [3:0]  i_opcode,
    input  wire         i_wide,
    input  wire  [63:0] i_first_operand,
    input  wire  [63:0] i_second_operand,
    input  wire  [2:0]  i_shift_kind,
    input  wire  [3:0]  i_extend_kind,
    input  wire  [5:0]  i_shift_amount,
    input  wire  [63:0] i_old_destination,
    output logic        o_strobe,
    output logic [63:0] o_result,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_c,
    output logic        o_flag_v,
    output logic        o_flags_valid
);
    import a64alu_pkg::*;

    // Stage 1: captured transaction.
    logic        r_s1_vld;
    logic [3:0]  r_s1_op;
    logic        r_s1_wide;
    logic [63:0] r_s1_a;
    logic [63:0] r_s1_b;
    logic [2:0]  r_s1_sk;
    logic [3:0]  r_s1_ext;
    logic [5:0]  r_s1_amt;
    logic [63:0] r_s1_old;

    // Stage 2: prepared operands.
    logic        r_s2_vld;
    logic [3:0]  r_s2_op;
    logic        r_s2_wide;
    logic [63:0] r_s2_a;
    logic [63:0] r_s2_b;
    logic [63:0] r_s2_imm;
    logic [63:0] r_s2_kmask;
    logic [63:0] r_s2_old;

    // Stage 3: raw ALU result and flag inputs.
    logic        r_s3_vld;
    logic        r_s3_wide;
    logic [63:0] r_s3_res;
    logic        r_s3_c;
    logic        r_s3_a_top;
    logic        r_s3_b_top;
    logic        r_s3_fv;
    logic        r_s3_arith;
    logic        r_s3_sub;

    // Stage 4: output registers.
    logic        r_o_vld;
    logic [63:0] r_o_res;
    logic        r_o_n;
    logic        r_o_z;
    logic        r_o_c;
    logic        r_o_v;
    logic        r_o_fv;

    logic        accept;

    // Operand stage signals.
    logic [5:0]         cnt;
    logic [63:0]        b_fit;
    logic [63:0]        ext_val;
    logic [63:0]        lsl_src;
    logic [63:0]        lsl_val;
    logic [63:0]        lsr_val;
    logic signed [63:0] asr_src;
    logic signed [63:0] asr_val;
    logic [127:0]       ror_wide;
    logic [63:0]        ror_narrow;
    logic [63:0]        n_b;
    logic [63:0]        n_a;
    logic [63:0]        n_imm;
    logic [63:0]        n_kmask;

    // ALU stage signals.
    logic [64:0] sum;
    logic [64:0] diff;
    logic [63:0] n_res;
    logic        n_c;
    logic        n_fv;
    logic        n_arith;
    logic        n_sub;

    // Flag stage signals.
    logic [63:0] res_fit;
    logic        res_top;
    logic        n_v;

    // The pipeline never holds a transaction back.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_o_vld  <= r_s3_vld;
        end
    end

    // Capture the transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_opcode;
            r_s1_wide <= i_wide;
            r_s1_a    <= i_first_operand;
            r_s1_b    <= i_second_operand;
            r_s1_sk   <= i_shift_kind;
            r_s1_ext  <= i_extend_kind;
            r_s1_amt  <= i_shift_amount;
            r_s1_old  <= i_old_destination;
        end
    end

    // Extend the second operand from the selected size.
    always_comb begin
        case (r_s1_ext)
            EXT_UXTB: ext_val = {56'd0, r_s1_b[7:0]};
            EXT_UXTH: ext_val = {48'd0, r_s1_b[15:0]};
            EXT_UXTW: ext_val = {32'd0, r_s1_b[31:0]};
            EXT_SXTB: ext_val = {{56{r_s1_b[7]}}, r_s1_b[7:0]};
            EXT_SXTH: ext_val = {{48{r_s1_b[15]}}, r_s1_b[15:0]};
            EXT_SXTW: ext_val = {{32{r_s1_b[31]}}, r_s1_b[31:0]};
            default:  ext_val = r_s1_b;
        endcase
    end

    // Shifters work at operand width; the count is masked to that width.
    always_comb begin
        cnt        = r_s1_amt & (r_s1_wide ? WIDE_CNT_MASK : NARROW_CNT_MASK);
        b_fit      = fit_width(r_s1_b, r_s1_wide);
        lsl_src    = (r_s1_ext != EXT_NONE) ? ext_val : r_s1_b;
        lsl_val    = fit_width(lsl_src << cnt, r_s1_wide);
        lsr_val    = b_fit >> cnt;
        asr_src    = r_s1_wide ? r_s1_b : {{32{r_s1_b[31]}}, r_s1_b[31:0]};
        asr_val    = asr_src >>> cnt;
        ror_wide   = {r_s1_b, r_s1_b} >> cnt;
        ror_narrow = {r_s1_b[31:0], r_s1_b[31:0]} >> cnt;
    end

    // Select the prepared second operand.
    always_comb begin
        if (r_s1_ext != EXT_NONE) begin
            n_b = lsl_val;
        end else begin
            case (r_s1_sk)
                SK_LSL:  n_b = lsl_val;
                SK_LSR:  n_b = lsr_val;
                SK_ASR:  n_b = fit_width(asr_val, r_s1_wide);
                SK_ROR:  n_b = r_s1_wide ? ror_wide[63:0] : {32'd0, ror_narrow[31:0]};
                default: n_b = b_fit;
            endcase
        end
    end

    // Negate runs as a subtract from zero; move forms use the 16-bit field.
    always_comb begin
        n_a     = ((r_s1_op == OP_NEG) || (r_s1_op == OP_NEGS)) ? 64'd0
                                                                : fit_width(r_s1_a, r_s1_wide);
        n_imm   = {48'd0, r_s1_b[15:0] & IMM16_MASK} << cnt;
        n_kmask = {48'd0, IMM16_MASK} << cnt;
    end

    // Operand stage registers.
    always_ff @(posedge i_clk) begin
        r_s2_op    <= r_s1_op;
        r_s2_wide  <= r_s1_wide;
        r_s2_a     <= n_a;
        r_s2_b     <= n_b;
        r_s2_imm   <= n_imm;
        r_s2_kmask <= n_kmask;
        r_s2_old   <= r_s1_old;
    end

    // Adder, subtracter and logic unit.
    always_comb begin
        sum     = {1'b0, r_s2_a} + {1'b0, r_s2_b};
        diff    = {1'b0, r_s2_a} - {1'b0, r_s2_b};
        n_res   = 64'd0;
        n_c     = 1'b0;
        n_fv    = 1'b0;
        n_arith = 1'b0;
        n_sub   = 1'b0;
        unique case (r_s2_op) inside
            OP_ADD: n_res = sum[63:0];
            OP_SUB, OP_NEG: n_res = diff[63:0];
            OP_AND: n_res = r_s2_a & r_s2_b;
            OP_ORR: n_res = r_s2_a | r_s2_b;
            OP_EOR: n_res = r_s2_a ^ r_s2_b;
            OP_ADDS: begin
                n_res   = sum[63:0];
                n_c     = r_s2_wide ? sum[64] : sum[32];
                n_fv    = 1'b1;
                n_arith = 1'b1;
            end
            OP_SUBS, OP_NEGS: begin
                n_res   = diff[63:0];
                n_c     = ~diff[64];
                n_fv    = 1'b1;
                n_arith = 1'b1;
                n_sub   = 1'b1;
            end
            OP_ANDS: begin
                n_res = r_s2_a & r_s2_b;
                n_fv  = 1'b1;
            end
            OP_BICS: begin
                n_res = r_s2_a & ~r_s2_b;
                n_fv  = 1'b1;
            end
            OP_MOVZ: n_res = r_s2_imm;
            OP_MOVK: n_res = (r_s2_old & ~r_s2_kmask) | r_s2_imm;
            OP_MOVN: n_res = ~r_s2_imm;
            default: n_res = 64'd0;
        endcase
    end

    // ALU stage registers.
    always_ff @(posedge i_clk) begin
        r_s3_wide  <= r_s2_wide;
        r_s3_res   <= n_res;
        r_s3_c     <= n_c;
        r_s3_a_top <= r_s2_wide ? r_s2_a[63] : r_s2_a[31];
        r_s3_b_top <= r_s2_wide ? r_s2_b[63] : r_s2_b[31];
        r_s3_fv    <= n_fv;
        r_s3_arith <= n_arith;
        r_s3_sub   <= n_sub;
    end

    // Width truncation and overflow.
    always_comb begin
        res_fit = fit_width(r_s3_res, r_s3_wide);
        res_top = r_s3_wide ? res_fit[63] : res_fit[31];
        if (r_s3_sub) begin
            n_v = r_s3_arith && (r_s3_a_top != r_s3_b_top) && (r_s3_a_top != res_top);
        end else begin
            n_v = r_s3_arith && (r_s3_a_top == r_s3_b_top) && (r_s3_a_top != res_top);
        end
    end

    // Output registers; flags read zero on forms that do not set them.
    always_ff @(posedge i_clk) begin
        r_o_res <= res_fit;
        r_o_n   <= r_s3_fv && res_top;
        r_o_z   <= r_s3_fv && (res_fit == 64'd0);
        r_o_c   <= r_s3_fv && r_s3_c;
        r_o_v   <= r_s3_fv && n_v;
        r_o_fv  <= r_s3_fv;
    end

    assign o_strobe      = r_o_vld;
    assign o_result      = r_o_res;
    assign o_flag_n      = r_o_n;
    assign o_flag_z      = r_o_z;
    assign o_flag_c      = r_o_c;
    assign o_flag_v      = r_o_v;
    assign o_flags_valid = r_o_fv;

endmodule

`default_nettype wire

@@ hdl/a64alu_checker.sv @@
// Port-level checker for the integer ALU and the bind that attaches it.
`timescale 1ns / 1ps
`default_nettype none

module a64alu_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        i_wide,
    input wire        o_strobe,
    input wire [63:0] o_result,
    input wire        o_flag_n,
    input wire        o_flag_z,
    input wire        o_flag_c,
    input wire        o_flag_v,
    input wire        o_flags_valid
);

    // Every accepted transaction yields a result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted transaction produced no result");

    // No result appears without an accepted transaction.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_strobe)
        else $error("result strobe without an accepted transaction");

    // A 32-bit transaction returns a zero upper word.
    a_narrow_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_wide) |-> ##4 (o_result[63:32] == 32'd0))
        else $error("upper word set on a 32-bit result");

    // Forms that do not set flags report all flags clear.
    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_flags_valid) |-> (!o_flag_n && !o_flag_z && !o_flag_c && !o_flag_v))
        else $error("flag set on a form that does not set flags");

    // The zero flag matches the result.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_flags_valid) |-> (o_flag_z == (o_result == 64'd0)))
        else $error("zero flag disagrees with result");

endmodule

bind arm64_alu_with_flags_core a64alu_checker u_a64alu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_wide        (i_wide),
    .o_strobe      (o_strobe),
    .o_result      (o_result),
    .o_flag_n      (o_flag_n),
    .o_flag_z      (o_flag_z),
    .o_flag_c      (o_flag_c),
    .o_flag_v      (o_flag_v),
    .o_flags_valid (o_flags_valid)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the 64-bit integer ALU with NZCV flags.
`timescale 1ns / 1ps

module tb_top;
    import a64alu_pkg::*;

    // One ALU transaction as it enters the block.
    typedef struct packed {
        logic [3:0]  op;
        logic        wide;
        logic [63:0] first;
        logic [63:0] second;
        logic [2:0]  shift;
        logic [3:0]  ext;
        logic [5:0]  amount;
        logic [63:0] old;
    } t_alu_cmd;

    // One result with its flags.
    typedef struct packed {
        logic [63:0] result;
        logic        n;
        logic        z;
        logic        c;
        logic        v;
        logic        fv;
    } t_alu_res;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        start             = 1'b0;
    logic [3:0]  i_opcode          = '0;
    logic        i_wide            = 1'b0;
    logic [63:0] i_first_operand   = '0;
    logic [63:0] i_second_operand  = '0;
    logic [2:0]  i_shift_kind      = '0;
    logic [3:0]  i_extend_kind     = '0;
    logic [5:0]  i_shift_amount    = '0;
    logic [63:0] i_old_destination = '0;
    wire         busy;
    wire         o_strobe;
    wire  [63:0] o_result;
    wire         o_flag_n;
    wire         o_flag_z;
    wire         o_flag_c;
    wire         o_flag_v;
    wire         o_flags_valid;

    t_alu_res pending_results[$];
    t_alu_res head_res;
    int       mismatches     = 0;
    int       stalled_cycles = 0;
    int       burst_left     = 0;

    arm64_alu_with_flags_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_wide            (i_wide),
        .i_first_operand   (i_first_operand),
        .i_second_operand  (i_second_operand),
        .i_shift_kind      (i_shift_kind),
        .i_extend_kind     (i_extend_kind),
        .i_shift_amount    (i_shift_amount),
        .i_old_destination (i_old_destination),
        .o_strobe          (o_strobe),
        .o_result          (o_result),
        .o_flag_n          (o_flag_n),
        .o_flag_z          (o_flag_z),
        .o_flag_c          (o_flag_c),
        .o_flag_v          (o_flag_v),
        .o_flags_valid     (o_flags_valid)
    );

    // Free-running 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Computes the destination value and NZCV of one transaction.
    function automatic t_alu_res alu_compute(input t_alu_cmd cmd);
        logic [5:0]         cnt;
        logic [63:0]        wmask;
        logic [63:0]        a;
        logic [63:0]        b;
        logic [63:0]        sx;
        logic signed [63:0] sar;
        logic [127:0]       dbl;
        logic [63:0]        imm;
        logic [63:0]        r;
        logic [64:0]        sum;
        logic               carry;
        logic               ovf;
        logic               sets_flags;
        int                 top;
        t_alu_res           res;
        cnt   = cmd.amount & (cmd.wide ? WIDE_CNT_MASK : NARROW_CNT_MASK);
        wmask = cmd.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        top   = cmd.wide ? 63 : 31;
        a     = cmd.first & wmask;

        // Second operand: an extend takes priority over the shift kind.
        if (cmd.ext != EXT_NONE) begin
            case (cmd.ext)
                EXT_UXTB: b = {56'd0, cmd.second[7:0]};
                EXT_UXTH: b = {48'd0, cmd.second[15:0]};
                EXT_UXTW: b = {32'd0, cmd.second[31:0]};
                EXT_SXTB: b = {{56{cmd.second[7]}}, cmd.second[7:0]};
                EXT_SXTH: b = {{48{cmd.second[15]}}, cmd.second[15:0]};
                EXT_SXTW: b = {{32{cmd.second[31]}}, cmd.second[31:0]};
                default:  b = cmd.second;
            endcase
            b = (b << cnt) & wmask;
        end else begin
            b  = cmd.second & wmask;
            sx = cmd.wide ? b : {{32{b[31]}}, b[31:0]};
            case (cmd.shift)
                SK_LSL: b = (b << cnt) & wmask;
                SK_LSR: b = b >> cnt;
                SK_ASR: begin
                    sar = $signed(sx) >>> cnt;
                    b   = sar & wmask;
                end
                SK_ROR: begin
                    // Rotate by shifting a doubled copy at operand width.
                    if (cmd.wide) begin
                        dbl = {b, b} >> cnt;
                        b   = dbl[63:0];
                    end else begin
                        dbl = {64'd0, b[31:0], b[31:0]} >> cnt;
                        b   = {32'd0, dbl[31:0]};
                    end
                end
                default: ;
            endcase
        end

        imm        = {48'd0, cmd.second[15:0]} << cnt;
        sum        = {1'b0, a} + {1'b0, b};
        sets_flags = 1'b0;
        carry      = 1'b0;
        ovf        = 1'b0;
        case (cmd.op) inside
            OP_ADD, OP_ADDS:  r = sum[63:0];
            OP_SUB, OP_SUBS:  r = a - b;
            OP_AND, OP_ANDS:  r = a & b;
            OP_ORR:           r = a | b;
            OP_EOR:           r = a ^ b;
            OP_BICS:          r = a & ~b;
            OP_NEG, OP_NEGS:  r = 64'd0 - b;
            OP_MOVZ:          r = imm;
            OP_MOVK:          r = (cmd.old & ~({48'd0, IMM16_MASK} << cnt)) | imm;
            OP_MOVN:          r = ~imm;
            default:          r = 64'd0;
        endcase
        r = r & wmask;

        // Carry and overflow are taken at operand width.
        case (cmd.op) inside
            OP_ADDS: begin
                sets_flags = 1'b1;
                carry      = cmd.wide ? sum[64] : sum[32];
                ovf        = 1'((~(a ^ b) & (a ^ r)) >> top);
            end
            OP_SUBS: begin
                sets_flags = 1'b1;
                carry      = (b <= a);
                ovf        = 1'(((a ^ b) & (a ^ r)) >> top);
            end
            OP_NEGS: begin
                sets_flags = 1'b1;
                carry      = (b == 64'd0);
                ovf        = 1'((b & r) >> top);
            end
            OP_ANDS, OP_BICS: sets_flags = 1'b1;
            default: ;
        endcase

        res.result = r;
        res.n      = sets_flags & r[top];
        res.z      = sets_flags & (r == 64'd0);
        res.c      = sets_flags & carry;
        res.v      = sets_flags & ovf;
        res.fv     = sets_flags;
        return res;
    endfunction

    // Idle length after a transaction: mostly short, a few long, with
    // back-to-back bursts in between.
    function automatic int next_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Operand values biased toward sign and carry boundaries.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 1));
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return {$urandom(), 32'h7FFF_FFFF + 32'($urandom_range(0, 2))};
            5: return {$urandom(), 32'hFFFF_FFFF};
            6: return 64'($urandom_range(0, 255));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Random transaction; flag_focus keeps to the flag-setting forms.
    function automatic t_alu_cmd random_cmd(input logic flag_focus);
        t_alu_cmd cmd;
        cmd.wide   = 1'($urandom_range(0, 1));
        cmd.first  = pick_operand();
        cmd.second = pick_operand();
        cmd.old    = {$urandom(), $urandom()};
        cmd.shift  = 3'($urandom_range(0, 7));
        if (flag_focus) begin
            case ($urandom_range(0, 4))
                0: cmd.op = OP_ADDS;
                1: cmd.op = OP_SUBS;
                2: cmd.op = OP_NEGS;
                3: cmd.op = OP_ANDS;
                default: cmd.op = OP_BICS;
            endcase
            cmd.ext    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 8)) : EXT_NONE;
            cmd.amount = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 3));
        end else begin
            cmd.op     = 4'($urandom_range(0, 15));
            cmd.ext    = $urandom_range(0, 1) ? EXT_NONE : 4'($urandom_range(1, 15));
            cmd.amount = 6'($urandom_range(0, 63));
        end
        return cmd;
    endfunction

    // Drives one transaction, waits for it to be taken, then idles for a random gap that may be zero.
    task automatic issue_cmd(input t_alu_cmd cmd);
        int gap;
        start             <= 1'b1;
        i_opcode          <= cmd.op;
        i_wide            <= cmd.wide;
        i_first_operand   <= cmd.first;
        i_second_operand  <= cmd.second;
        i_shift_kind      <= cmd.shift;
        i_extend_kind     <= cmd.ext;
        i_shift_amount    <= cmd.amount;
        i_old_destination <= cmd.old;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(alu_compute(cmd));
        gap = next_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every opcode, including the two unused ones, with extreme operands.
    task automatic test_every_opcode();
        t_alu_cmd cmd;
        for (int op = 0; op < 16; op++) begin
            cmd.op     = 4'(op);
            cmd.wide   = op[0];
            cmd.first  = op[1] ? 64'hFFFF_FFFF_8000_0001 : 64'h8000_0000_0000_0000;
            cmd.second = op[2] ? 64'h0000_0000_0001_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
            cmd.shift  = op[3] ? SK_LSL : SK_NONE;
            cmd.ext    = EXT_NONE;
            cmd.amount = 6'd63;
            cmd.old    = 64'hFFFF_FFFF_FFFF_FFFF;
            issue_cmd(cmd);
        end
    endtask

    // Carry, overflow, narrow shifts, unused codes and the move forms.
    task automatic test_special_cases();
        t_alu_cmd cmd;
        cmd = '{op: OP_ADDS, wide: 1'b1, first: '1, second: 64'd1, shift: SK_NONE,
                ext: EXT_NONE, amount: 6'd0, old: '0};
        issue_cmd(cmd);
        cmd.first = 64'h7FFF_FFFF_FFFF_FFFF;
        issue_cmd(cmd);
        // Narrow subtract that borrows, with garbage in the upper words.
        cmd = '{op: OP_SUBS, wide: 1'b0, first: 64'hABCD_0000_0000_0000,
                second: 64'h1234_0000_0000_0001, shift: SK_NONE, ext: EXT_NONE,
                amount: 6'd0, old: '0};
        issue_cmd(cmd);
        // Negate of zero is the one negate that sets carry.
        cmd = '{op: OP_NEGS, wide: 1'b1, first: '1, second: 64'd0, shift: SK_NONE,
                ext: EXT_NONE, amount: 6'd0, old: '0};
        issue_cmd(cmd);
        cmd.wide   = 1'b0;
        cmd.second = 64'hFFFF_FFFF_8000_0000;
        issue_cmd(cmd);
        // Narrow arithmetic shift takes its sign from bit 31.
        cmd = '{op: OP_SUB, wide: 1'b0, first: 64'd0, second: 64'h0000_0000_8000_0000,
                shift: SK_ASR, ext: EXT_NONE, amount: 6'd36, old: '0};
        issue_cmd(cmd);
        // Narrow rotate stays within 32 bits.
        cmd = '{op: OP_ORR, wide: 1'b0, first: 64'd0, second: 64'h0000_00FF_0000_00AB,
                shift: SK_ROR, ext: EXT_NONE, amount: 6'd8, old: '0};
        issue_cmd(cmd);
        // Unused extend code: no extension, but the left shift still applies.
        cmd = '{op: OP_ADD, wide: 1'b1, first: 64'd1, second: 64'hF000_0000_0000_00FF,
                shift: SK_LSR, ext: 4'd13, amount: 6'd3, old: '0};
        issue_cmd(cmd);
        // Unused shift code passes the operand through.
        cmd = '{op: OP_EOR, wide: 1'b1, first: 64'h5555_5555_5555_5555,
                second: 64'hFFFF_0000_FFFF_0000, shift: 3'd6, ext: EXT_NONE,
                amount: 6'd10, old: '0};
        issue_cmd(cmd);
        // Signed word extend followed by a left shift.
        cmd = '{op: OP_ADD, wide: 1'b1, first: 64'd0, second: 64'h0000_0000_8000_0001,
                shift: SK_NONE, ext: EXT_SXTW, amount: 6'd2, old: '0};
        issue_cmd(cmd);
        // Keep-move into the top halfword, then a narrow inverted move.
        cmd = '{op: OP_MOVK, wide: 1'b1, first: '0, second: 64'hFFFF_FFFF_FFFF_BEEF,
                shift: SK_NONE, ext: EXT_NONE, amount: 6'd48, old: 64'h0123_4567_89AB_CDEF};
        issue_cmd(cmd);
        cmd.op   = OP_MOVN;
        cmd.wide = 1'b0;
        issue_cmd(cmd);
    endtask

    // Flag-setting forms with operands at the sign and carry boundaries.
    task automatic test_flag_boundaries(input int count);
        for (int i = 0; i < count; i++) issue_cmd(random_cmd(1'b1));
    endtask

    // Fully random transactions over every field.
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) issue_cmd(random_cmd(1'b0));
    endtask

    // Compares one field of a result with its predicted value.
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Each strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                mismatches++;
            end else begin
                head_res = pending_results.pop_front();
                check_field("result", head_res.result, o_result);
                check_field("flag_n", 64'(head_res.n), 64'(o_flag_n));
                check_field("flag_z", 64'(head_res.z), 64'(o_flag_z));
                check_field("flag_c", 64'(head_res.c), 64'(o_flag_c));
                check_field("flag_v", 64'(head_res.v), 64'(o_flag_v));
                check_field("flags_valid", 64'(head_res.fv), 64'(o_flags_valid));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        while (stalled_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1)
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_every_opcode();
        test_special_cases();
        test_flag_boundaries(350);
        test_random_mix(950);
        start <= 1'b0;

        // Drain the pipeline, then watch for stray strobes.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
